// ===== src/transposition_table_probe_store_top_defines.svh =====
// assertion macros for the transposition table rtl
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_TOP_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_TOP_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define TTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define TTPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTPS_ASSERT(lbl, prop, msg)
`define TTPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/ttps_pkg.sv =====
// shared constants and types of the transposition table
package ttps_pkg;

  // entry count, a power of two: the slot is the low key bits
  localparam int TABLE_ENTRIES = 1024;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 16;
  localparam int KIND_W  = 2;
  // full key kept: a cleared slot holds key 0, which only slot 0 can match
  localparam int LOCK_W  = KEY_W;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_PROBE  = 1'b0;
  localparam logic MODE_RECORD = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

  typedef struct packed {
    logic                      is_record;
    logic [SLOT_W-1:0]         slot;
    logic [LOCK_W-1:0]         lock;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         kind;
  } cmd_t;

  typedef struct packed {
    logic [LOCK_W-1:0]         lock;
    logic [DEPTH_W-1:0]        depth;
    logic [KIND_W-1:0]         kind;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                      hit;
    logic signed [SCORE_W-1:0] score;
  } res_t;

  // status from back part to front part
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage

// ===== src/transposition_table_probe_store_top.sv =====
// top level of the always-replace transposition table
// Transposition table with 1024 slots and always-replace policy. Each input item
// is a probe (s_tuser 0) or a record (s_tuser 1) of a 64-bit position key; the
// slot is the low 10 key bits and the full key is kept for the match. A record
// overwrites its slot and gives no result; a probe gives one result item: hit
// in m_tuser and the score (stored score, alpha or beta by bound kind) in
// m_tdata, with hit 0 and score 0 on a miss.
// After reset the table runs a clearing pass, one slot per cycle, and takes
// no item until it ends. After that records are taken at one per cycle while
// no probe ahead of them waits in the command queue. A probe issues to the
// table only when the result queue has a place for it, counting the read
// still in flight, so a new probe can issue while the last one's read is
// still out; a stalled output fills the result queue, then the command queue,
// and s_tready drops. With both queues empty a probe's result is written into
// the result queue once the probe has issued from the command queue and the
// registered table read has returned, and it can then be taken. Between the
// front and back a two-item command queue decouples input stalls from output
// stalls; a two-item result queue holds finished results.
module transposition_table_probe_store_top (
  input  logic                             clk,
  input  logic                             rst,
  // item input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // position_key[63:0], search_depth[71:64], alpha_bound[87:72],
  // beta_bound[103:88], entry_score[119:104], bound_kind[121:120], zero above
  input  logic [ttps_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode: 0 probe, 1 record
  input  logic                             s_tuser,
  // result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // result_score[15:0]
  output logic [ttps_pkg::OUT_TDATA_W-1:0] m_tdata,
  // hit
  output logic                             m_tuser
);
  import ttps_pkg::*;

  back_stat_t stat;
  logic       cmd_valid;
  cmd_t       cmd;

  // front: decode and queue commands
  ttps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .stat      (stat),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // back: clear, access table, evaluate probes, queue results
  ttps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== src/ttps_ram.sv =====
// generic single write port ram with registered read
module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ttps_front.sv =====
// front part: accepts items, decodes them into commands, holds the command queue
module ttps_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ttps_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  input  ttps_pkg::back_stat_t             stat,
  output logic                             cmd_valid,
  output ttps_pkg::cmd_t                   cmd
);
  import ttps_pkg::*;

  cmd_t              cmd_in;
  logic [KEY_W-1:0]  key;
  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              push;
  logic              pop;

  // tdata: key, depth, alpha, beta, score, kind from bit 0 up
  assign key              = s_tdata[63:0];
  assign cmd_in.is_record = (s_tuser == MODE_RECORD);
  assign cmd_in.slot      = key[SLOT_W-1:0];
  assign cmd_in.lock      = key;
  assign cmd_in.depth     = s_tdata[71:64];
  assign cmd_in.alpha     = s_tdata[87:72];
  assign cmd_in.beta      = s_tdata[103:88];
  assign cmd_in.score     = s_tdata[119:104];
  assign cmd_in.kind      = s_tdata[121:120];

  assign s_tready  = (cnt != QCNT_W'(QUEUE_DEPTH)) && !stat.clearing;
  assign push      = s_tvalid && s_tready;
  assign pop       = stat.take;
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== src/ttps_back.sv =====
// back part: clearing pass, table access, probe evaluation and result queue
module ttps_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  ttps_pkg::cmd_t                   cmd,
  output ttps_pkg::back_stat_t             stat,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ttps_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tuser
);
  import ttps_pkg::*;

  `include "transposition_table_probe_store_top_defines.svh"

  logic                      clearing;
  logic [SLOT_W-1:0]         clr_addr;
  logic                      room;
  logic                      issue;
  logic                      ram_we;
  logic [SLOT_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic                      ram_re;
  logic [ENTRY_W-1:0]        ram_rdata;
  entry_t                    new_entry;
  entry_t                    found;
  logic                      rd_pending;
  logic [LOCK_W-1:0]         pr_lock;
  logic [DEPTH_W-1:0]        pr_depth;
  logic signed [SCORE_W-1:0] pr_alpha;
  logic signed [SCORE_W-1:0] pr_beta;
  res_t                      res;
  res_t                      oq [QUEUE_DEPTH];
  logic [QPTR_W-1:0]         o_wr_ptr;
  logic [QPTR_W-1:0]         o_rd_ptr;
  logic [QCNT_W-1:0]         out_cnt;
  logic                      o_push;
  logic                      o_pop;

  // a probe goes out only when its result is sure of a place in the result queue
  assign room  = (out_cnt + QCNT_W'(rd_pending)) < QCNT_W'(QUEUE_DEPTH);
  assign issue = cmd_valid && !clearing && (cmd.is_record || room);

  assign stat.clearing = clearing;
  assign stat.take     = issue;

  assign new_entry.lock  = cmd.lock;
  assign new_entry.depth = cmd.depth;
  assign new_entry.kind  = cmd.kind;
  assign new_entry.score = cmd.score;

  assign ram_we    = clearing || (issue && cmd.is_record);
  assign ram_waddr = clearing ? clr_addr : cmd.slot;
  assign ram_wdata = clearing ? '0 : new_entry;
  assign ram_re    = issue && !cmd.is_record;

  ttps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cmd.slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SLOT_W'(TABLE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pr_lock  <= cmd.lock;
      pr_depth <= cmd.depth;
      pr_alpha <= cmd.alpha;
      pr_beta  <= cmd.beta;
    end
  end

  assign found = ram_rdata;

  always_comb begin
    res.hit   = 1'b0;
    res.score = '0;
    if ((found.lock == pr_lock) && (found.depth >= pr_depth)) begin
      case (found.kind)
        KIND_EXACT: begin
          res.hit   = 1'b1;
          res.score = found.score;
        end
        KIND_UPPER: begin
          if (found.score <= pr_alpha) begin
            res.hit   = 1'b1;
            res.score = pr_alpha;
          end
        end
        KIND_LOWER: begin
          if (found.score >= pr_beta) begin
            res.hit   = 1'b1;
            res.score = pr_beta;
          end
        end
        default: begin
          res.hit   = 1'b0;
          res.score = '0;
        end
      endcase
    end
  end

  assign o_push   = rd_pending;
  assign o_pop    = m_tvalid && m_tready;
  assign m_tvalid = (out_cnt != '0);
  assign m_tdata  = oq[o_rd_ptr].score;
  assign m_tuser  = oq[o_rd_ptr].hit;

  always_ff @(posedge clk) begin
    if (o_push) begin
      oq[o_wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr_ptr <= '0;
      o_rd_ptr <= '0;
      out_cnt  <= '0;
    end else begin
      if (o_push) begin
        o_wr_ptr <= o_wr_ptr + 1'b1;
      end
      if (o_pop) begin
        o_rd_ptr <= o_rd_ptr + 1'b1;
      end
      case ({o_push, o_pop})
        2'b10:   out_cnt <= out_cnt + 1'b1;
        2'b01:   out_cnt <= out_cnt - 1'b1;
        default: out_cnt <= out_cnt;
      endcase
    end
  end

  `TTPS_ASSERT(a_no_issue_while_clearing, !(clearing && issue), "item issued during clear")
  `TTPS_ASSERT(a_result_has_room, !(o_push && !o_pop && (out_cnt == QCNT_W'(QUEUE_DEPTH))), "result queue overflow")
  `TTPS_ASSERT_NEXT(a_clear_ends, clearing && (clr_addr == SLOT_W'(TABLE_ENTRIES - 1)), !clearing, "clear did not end")
  `TTPS_ASSERT(a_miss_is_zero, !(o_push && !res.hit && (res.score != '0)), "miss with nonzero score")
  `TTPS_ASSERT_NEXT(a_read_lands, ram_re, rd_pending, "table read lost")

endmodule
